// ===== src/dsdc_pkg.sv =====
package dsdc_pkg;

	// Request direction codes
	localparam logic REQ_S2D = 1'b0;
	localparam logic REQ_D2S = 1'b1;

	localparam int DOY_W = 9;
	localparam int MONTHS_PER_YEAR = 12;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;
	localparam logic [DOY_W-1:0] FEB_LAST_DOY = 9'd58;
	localparam int DAYS_PER_YEAR = 365;

	// floor(n / 100) == (n * RECIP_100) >> RECIP_SHIFT for any n below 8192
	localparam int RECIP_W = 13;
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
	localparam int RECIP_SHIFT = 19;

	localparam logic [4:0] MONTH_LEN [MONTHS_PER_YEAR] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	localparam logic [DOY_W-1:0] MONTH_START [MONTHS_PER_YEAR] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	typedef struct packed {
		logic        req_type;
		logic [16:0] day_serial;
		logic [11:0] year_in;
		logic [3:0]  month_in;
		logic [4:0]  day_in;
	} req_t;

	typedef struct packed {
		logic [16:0] serial_out;
		logic [11:0] year_out;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic        bad_input;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PROD,
		ST_STEP,
		ST_YEAR,
		ST_SPLIT,
		ST_MONTH,
		ST_DATE,
		ST_SERIAL,
		ST_BAD
	} state_t;

	typedef struct packed {
		logic load;
		logic search_init;
		logic use_cand;
		logic step;
		logic split;
		logic res_month;
		logic res_serial;
		logic res_bad;
	} cmd_t;

	typedef struct packed {
		logic is_d2s;
		logic serial_bad;
		logic date_bad;
		logic last_bit;
	} sts_t;

endpackage

// ===== src/dsdc_year_unit.sv =====
module dsdc_year_unit #(
	parameter int BASE_YEAR = 1900,
	parameter int NUM_YEARS = 300
) (
	input  logic                                          clk,
	input  logic [((NUM_YEARS > 1) ? $clog2(NUM_YEARS) : 1)-1:0] off,
	output logic [$clog2(365*NUM_YEARS + NUM_YEARS/4 + 2)-1:0]    year_start,
	output logic                                          leap
);

	localparam int OFF_W = (NUM_YEARS > 1) ? $clog2(NUM_YEARS) : 1;
	localparam int YS_W  = $clog2(365*NUM_YEARS + NUM_YEARS/4 + 2);
	localparam int YA_W  = $clog2(BASE_YEAR + NUM_YEARS);
	localparam int MUL_W = YA_W + dsdc_pkg::RECIP_W;
	localparam int Q_W   = MUL_W - dsdc_pkg::RECIP_SHIFT;
	localparam int L_FY  = (BASE_YEAR-1)/4 - (BASE_YEAR-1)/100 + (BASE_YEAR-1)/400;

	logic [YA_W-1:0]  yr;
	logic [YA_W-1:0]  yr_m1;
	logic [MUL_W-1:0] prod_a;
	logic [MUL_W-1:0] prod_b;
	logic [Q_W-1:0]   q_a;
	logic [Q_W-1:0]   q_b;
	logic             cent;
	logic [YS_W-1:0]  p365_s1;
	logic [YA_W-1:0]  n_s1;
	logic [Q_W-1:0]   q_s1;
	logic             leap_s1;

	assign yr     = YA_W'(BASE_YEAR) + YA_W'(off);
	assign yr_m1  = yr - YA_W'(1);
	assign prod_a = MUL_W'(yr_m1) * MUL_W'(dsdc_pkg::RECIP_100);
	assign prod_b = MUL_W'(yr) * MUL_W'(dsdc_pkg::RECIP_100);
	assign q_a    = prod_a[MUL_W-1:dsdc_pkg::RECIP_SHIFT];
	assign q_b    = prod_b[MUL_W-1:dsdc_pkg::RECIP_SHIFT];
	// the century count steps exactly at multiples of 100
	assign cent   = (q_b != q_a);

	always_ff @(posedge clk) begin
		p365_s1 <= YS_W'(off) * YS_W'(dsdc_pkg::DAYS_PER_YEAR);
		n_s1    <= yr_m1;
		q_s1    <= q_a;
		leap_s1 <= (yr[1:0] == 2'd0) && (!cent || (q_b[1:0] == 2'd0));
	end

	// days before this year, relative to the first year, leap days included
	assign year_start = p365_s1 + YS_W'(n_s1 >> 2) - YS_W'(q_s1) + YS_W'(q_s1 >> 2)
		- YS_W'(L_FY);
	assign leap = leap_s1;

endmodule

// ===== src/dsdc_datapath.sv =====
module dsdc_datapath #(
	parameter int BASE_YEAR = 1900,
	parameter int NUM_YEARS = 300
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dsdc_pkg::req_t  request,
	input  dsdc_pkg::cmd_t  cmd,
	output dsdc_pkg::sts_t  sts,
	output dsdc_pkg::res_t  result
);

	localparam int OFF_W  = (NUM_YEARS > 1) ? $clog2(NUM_YEARS) : 1;
	localparam int BIT_W  = (OFF_W > 1) ? $clog2(OFF_W) : 1;
	localparam int YS_W   = $clog2(365*NUM_YEARS + NUM_YEARS/4 + 2);
	localparam int CMP_W  = (YS_W > 17) ? YS_W : 17;
	localparam int YC_R   = $clog2(BASE_YEAR + NUM_YEARS + 1);
	localparam int YC_W   = (YC_R > 12) ? YC_R : 12;
	localparam int LAST_Y = BASE_YEAR + NUM_YEARS - 1;
	localparam int L_FY   = (BASE_YEAR-1)/4 - (BASE_YEAR-1)/100 + (BASE_YEAR-1)/400;
	localparam int L_END  = LAST_Y/4 - LAST_Y/100 + LAST_Y/400;
	localparam int YS_END = 365*NUM_YEARS + L_END - L_FY;
	localparam int DOY_W  = dsdc_pkg::DOY_W;

	dsdc_pkg::req_t   item_q;
	dsdc_pkg::res_t   res_q;
	logic [OFF_W-1:0] lo_q;
	logic [BIT_W-1:0] bit_q;
	logic [DOY_W-1:0] s_q;
	logic             after_q;

	logic [OFF_W-1:0] cand;
	logic             cand_ok;
	logic [YC_W-1:0]  year_ext;
	logic [OFF_W-1:0] yoff;
	logic [OFF_W-1:0] unit_off;
	logic [YS_W-1:0]  ys;
	logic             leap;
	logic [CMP_W-1:0] diff;
	logic [DOY_W-1:0] s_raw;
	logic [3:0]       m;
	logic [4:0]       day_v;
	logic [YC_W-1:0]  year_v;
	logic [3:0]       mi;
	logic [4:0]       dmax;
	logic [DOY_W-1:0] doy;
	logic [CMP_W-1:0] serial_v;
	logic             day_ok;

	dsdc_year_unit #(
		.BASE_YEAR  (BASE_YEAR),
		.NUM_YEARS  (NUM_YEARS)
	) u_year (
		.clk        (clk),
		.off        (unit_off),
		.year_start (ys),
		.leap       (leap)
	);

	assign cand     = lo_q | (OFF_W'(1) << bit_q);
	assign cand_ok  = (cand <= OFF_W'(NUM_YEARS - 1));
	assign year_ext = YC_W'(item_q.year_in);
	assign yoff     = OFF_W'(year_ext - YC_W'(BASE_YEAR));

	always_comb begin
		if (cmd.use_cand) begin
			unit_off = cand;
		end else if (item_q.req_type == dsdc_pkg::REQ_D2S) begin
			unit_off = yoff;
		end else begin
			unit_off = lo_q;
		end
	end

	assign sts.is_d2s     = (item_q.req_type == dsdc_pkg::REQ_D2S);
	assign sts.serial_bad = (CMP_W'(item_q.day_serial) >= CMP_W'(YS_END));
	assign sts.date_bad   = (year_ext < YC_W'(BASE_YEAR))
		|| (year_ext >= YC_W'(BASE_YEAR + NUM_YEARS))
		|| (item_q.month_in == 4'd0) || (item_q.month_in > dsdc_pkg::MONTH_DEC);
	assign sts.last_bit   = (bit_q == '0);

	assign diff  = CMP_W'(item_q.day_serial) - CMP_W'(ys);
	assign s_raw = diff[DOY_W-1:0];

	always_comb begin
		m = 4'd0;
		for (int k = 1; k < dsdc_pkg::MONTHS_PER_YEAR; k++) begin
			if (s_q >= dsdc_pkg::MONTH_START[k]) m = m + 4'd1;
		end
	end

	assign day_v  = 5'(s_q - dsdc_pkg::MONTH_START[m]) + 5'd1
		+ 5'((m == 4'd1) && after_q);
	assign year_v = YC_W'(BASE_YEAR) + YC_W'(lo_q);

	assign mi       = item_q.month_in - 4'd1;
	assign dmax     = dsdc_pkg::MONTH_LEN[mi]
		+ 5'((item_q.month_in == dsdc_pkg::MONTH_FEB) && leap);
	assign day_ok   = (item_q.day_in != 5'd0) && (item_q.day_in <= dmax);
	assign doy      = dsdc_pkg::MONTH_START[mi]
		+ DOY_W'((item_q.month_in > dsdc_pkg::MONTH_FEB) && leap)
		+ DOY_W'(item_q.day_in) - DOY_W'(1);
	assign serial_v = CMP_W'(ys) + CMP_W'(doy);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= request;
		end
		if (cmd.search_init) begin
			lo_q  <= '0;
			bit_q <= BIT_W'(OFF_W - 1);
		end else if (cmd.step) begin
			if (cand_ok && (CMP_W'(ys) <= CMP_W'(item_q.day_serial))) lo_q <= cand;
			bit_q <= bit_q - BIT_W'(1);
		end
		if (cmd.split) begin
			// drop leap day from the day-of-year, remember it for February
			if (leap && (s_raw > dsdc_pkg::FEB_LAST_DOY)) begin
				s_q     <= s_raw - DOY_W'(1);
				after_q <= 1'b1;
			end else begin
				s_q     <= s_raw;
				after_q <= 1'b0;
			end
		end
		if (cmd.res_month) begin
			res_q.serial_out <= '0;
			res_q.year_out   <= year_v[11:0];
			res_q.month_out  <= m + 4'd1;
			res_q.day_out    <= day_v;
			res_q.bad_input  <= 1'b0;
		end else if (cmd.res_serial) begin
			res_q.serial_out <= day_ok ? serial_v[16:0] : 17'd0;
			res_q.year_out   <= '0;
			res_q.month_out  <= '0;
			res_q.day_out    <= '0;
			res_q.bad_input  <= !day_ok;
		end else if (cmd.res_bad) begin
			res_q <= '{serial_out: '0, year_out: '0, month_out: '0, day_out: '0,
				bad_input: 1'b1};
		end
	end

	assign result = res_q;

	a_lo_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> (lo_q >= $past(lo_q)))
		else $error("year search moved backward");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_month |=> ((res_q.month_out >= 4'd1) && (res_q.month_out <= dsdc_pkg::MONTH_DEC)
			&& (res_q.day_out != 5'd0)))
		else $error("serial to date produced an impossible month or day");

	a_bad_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_bad |=> (res_q.bad_input && (res_q.serial_out == 17'd0)
			&& (res_q.year_out == 12'd0)))
		else $error("bad item result carries data");

endmodule

// ===== src/dsdc_ctrl.sv =====
module dsdc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  dsdc_pkg::sts_t sts,
	output dsdc_pkg::cmd_t cmd,
	output logic           busy,
	output logic           done
);

	dsdc_pkg::state_t state_q;
	dsdc_pkg::state_t state_nxt;
	logic             done_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dsdc_pkg::ST_IDLE: begin
				if (start) state_nxt = dsdc_pkg::ST_CHECK;
			end
			dsdc_pkg::ST_CHECK: begin
				if (sts.is_d2s) begin
					state_nxt = sts.date_bad ? dsdc_pkg::ST_BAD : dsdc_pkg::ST_DATE;
				end else begin
					state_nxt = sts.serial_bad ? dsdc_pkg::ST_BAD : dsdc_pkg::ST_PROD;
				end
			end
			dsdc_pkg::ST_PROD:   state_nxt = dsdc_pkg::ST_STEP;
			dsdc_pkg::ST_STEP: begin
				state_nxt = sts.last_bit ? dsdc_pkg::ST_YEAR : dsdc_pkg::ST_PROD;
			end
			dsdc_pkg::ST_YEAR:   state_nxt = dsdc_pkg::ST_SPLIT;
			dsdc_pkg::ST_SPLIT:  state_nxt = dsdc_pkg::ST_MONTH;
			dsdc_pkg::ST_MONTH:  state_nxt = dsdc_pkg::ST_IDLE;
			dsdc_pkg::ST_DATE:   state_nxt = dsdc_pkg::ST_SERIAL;
			dsdc_pkg::ST_SERIAL: state_nxt = dsdc_pkg::ST_IDLE;
			dsdc_pkg::ST_BAD:    state_nxt = dsdc_pkg::ST_IDLE;
			default:             state_nxt = dsdc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			dsdc_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			dsdc_pkg::ST_CHECK: begin
				cmd.search_init = 1'b1;
			end
			dsdc_pkg::ST_PROD: begin
				cmd.use_cand = 1'b1;
			end
			dsdc_pkg::ST_STEP: begin
				cmd.use_cand = 1'b1;
				cmd.step     = 1'b1;
			end
			dsdc_pkg::ST_YEAR:   cmd.use_cand = 1'b0;
			dsdc_pkg::ST_SPLIT:  cmd.split = 1'b1;
			dsdc_pkg::ST_MONTH:  cmd.res_month = 1'b1;
			dsdc_pkg::ST_DATE:   cmd.use_cand = 1'b0;
			dsdc_pkg::ST_SERIAL: cmd.res_serial = 1'b1;
			dsdc_pkg::ST_BAD:    cmd.res_bad = 1'b1;
			default:             busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsdc_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= cmd.res_month || cmd.res_serial || cmd.res_bad;
		end
	end

	assign done = done_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted item did not make the block busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule

// ===== src/day_serial_date_converter.sv =====
// Day serial <-> Gregorian date converter.
// Request channel: drive request and raise start; the item is taken at the
// rising edge where start is high and busy is low. req_type chooses the
// direction: serial to date, or date to serial.
// Result channel: done is high for exactly one cycle while result holds the
// answer; the receiver must take it then, it cannot stall the block.
// Controller states after the accepting edge, per kind of item:
//   date to serial       : check, date, serial (also for a bad day)
//   invalid serial/date  : check, bad (serial, year or month out of range)
//   serial to date       : check, B search steps, year, split, month
// A serial-to-date item runs a binary search for the year in B steps,
// B = ceil(log2(NUM_YEARS)), each through the shared year-start unit
// (a registered multiply stage, then the add and compare), followed by
// one more pass for the chosen year, the day split and the month lookup.
// One item is in flight at a time; busy drops in the done cycle, so the
// next item can be accepted while the result is on the ports.
// Reset (arst_n low) returns the controller to idle and clears done; there
// is no clearing pass and no stored state beyond the item in flight.
module day_serial_date_converter #(
	parameter int BASE_YEAR = 1900,
	parameter int NUM_YEARS = 300
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  dsdc_pkg::req_t request,
	output logic           busy,
	output logic           done,
	output dsdc_pkg::res_t result
);

	// command and status between sequencer and datapath
	dsdc_pkg::cmd_t cmd;
	dsdc_pkg::sts_t sts;

	// sequencer: accept, check, search the year, split, finish
	dsdc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath: hold the item, run the year-start unit, build the result
	dsdc_datapath #(
		.BASE_YEAR (BASE_YEAR),
		.NUM_YEARS (NUM_YEARS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.result  (result)
	);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	// Calendar window of the block under test
	localparam int FIRST_YR   = 1900;
	localparam int YEAR_COUNT = 300;
	localparam int END_YR     = FIRST_YR + YEAR_COUNT;
	// Last valid serial: 31 Dec of the final year
	localparam int LAST_SERIAL = 109572;
	// Cycles with neither a request nor a result taken before giving up
	localparam int STALL_LIMIT = 4000;
	// Idle time at the end, longer than the longest (serial-to-date) conversion
	localparam int DRAIN_CYCLES = 40;

	localparam int unsigned COMMON_MONTH_LEN [12] = '{
		31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
	};
	localparam int unsigned DAYS_BEFORE [12] = '{
		0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
	};

	logic clk;
	logic arst_n;
	logic start;
	dsdc_pkg::req_t request;
	logic busy;
	logic done;
	dsdc_pkg::res_t result;

	dsdc_pkg::req_t req_q [$];    // requests waiting for the driver
	dsdc_pkg::res_t answer_q [$]; // predicted answers, oldest first
	int   idle_pct;     // chance in percent that the driver holds start low
	logic taken;        // a request was taken at the last rising edge
	int   mismatch_cnt;
	int   stall_cnt;

	day_serial_date_converter #(
		.BASE_YEAR(FIRST_YR),
		.NUM_YEARS(YEAR_COUNT)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.request(request),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ---------------------------------------------------------------
	// Calendar arithmetic for the predictor
	// ---------------------------------------------------------------

	function automatic bit is_leap(int unsigned y);
		if (y % 4 != 0) return 1'b0;
		if (y % 100 != 0) return 1'b1;
		return (y % 400) == 0;
	endfunction

	// Count of leap years among 1..n
	function automatic int unsigned leaps_through(int unsigned n);
		return n / 4 - n / 100 + n / 400;
	endfunction

	// Serial of 1 January of year y (y at or above the first year)
	function automatic int unsigned jan1_serial(int unsigned y);
		return 365 * (y - FIRST_YR) + leaps_through(y - 1) - leaps_through(FIRST_YR - 1);
	endfunction

	function automatic int unsigned month_days(int unsigned y, int unsigned m);
		return COMMON_MONTH_LEN[m - 1] + ((m == 2 && is_leap(y)) ? 1 : 0);
	endfunction

	// Work out the answer the converter must give for one request
	function automatic dsdc_pkg::res_t convert_date(dsdc_pkg::req_t rq);
		dsdc_pkg::res_t r;
		int unsigned sn;
		int unsigned y;
		int unsigned doy;
		int unsigned m;
		bit          past_feb28;
		bit          valid;
		r = '0;
		if (rq.req_type == dsdc_pkg::REQ_S2D) begin
			sn = rq.day_serial;
			if (sn > jan1_serial(END_YR) - 1) begin
				r.bad_input = 1'b1;
			end else begin
				// Start from an underestimate of the year and walk up
				y = FIRST_YR + sn / 366;
				while (y + 1 < END_YR && jan1_serial(y + 1) <= sn)
					y++;
				doy = sn - jan1_serial(y);
				past_feb28 = 1'b0;
				// Fold the leap day away so the common-year month table applies
				if (is_leap(y) && doy > 58) begin
					doy--;
					past_feb28 = 1'b1;
				end
				m = 0;
				while (m < 11 && DAYS_BEFORE[m + 1] <= doy)
					m++;
				r.year_out  = 12'(y);
				r.month_out = 4'(m + 1);
				// 29 February lands on the folded 28 February
				r.day_out   = 5'(1 + doy - DAYS_BEFORE[m] + ((m == 1 && past_feb28) ? 1 : 0));
			end
		end else begin
			valid = rq.year_in >= FIRST_YR && rq.year_in < END_YR
				&& rq.month_in >= 1 && rq.month_in <= 12;
			if (valid)
				valid = rq.day_in >= 1 && rq.day_in <= month_days(rq.year_in, rq.month_in);
			if (!valid) begin
				r.bad_input = 1'b1;
			end else begin
				doy = DAYS_BEFORE[rq.month_in - 1]
					+ ((rq.month_in > 2 && is_leap(rq.year_in)) ? 1 : 0) + (rq.day_in - 1);
				r.serial_out = 17'(jan1_serial(rq.year_in) + doy);
			end
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	// Queue one request; fields the direction ignores get random content
	task automatic push_req(logic kind, int unsigned sn, int unsigned y, int unsigned m,
			int unsigned d);
		dsdc_pkg::req_t rq;
		rq = dsdc_pkg::req_t'({$urandom, $urandom});
		rq.req_type = kind;
		if (kind == dsdc_pkg::REQ_S2D) begin
			rq.day_serial = 17'(sn);
		end else begin
			rq.year_in  = 12'(y);
			rq.month_in = 4'(m);
			rq.day_in   = 5'(d);
		end
		req_q.push_back(rq);
	endtask

	// Mostly well-formed requests in range, the rest noise over full widths
	task automatic push_random(int count);
		int          pick;
		int unsigned y;
		int unsigned m;
		int unsigned sn;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99, 0);
			if (pick < 30) begin
				push_req(dsdc_pkg::REQ_S2D, $urandom_range(LAST_SERIAL, 0), 0, 0, 0);
			end else if (pick < 42) begin
				// Hug a year boundary, where the year search is most fragile
				y = $urandom_range(END_YR, FIRST_YR + 1);
				sn = jan1_serial(y) - 1 + $urandom_range(1, 0);
				push_req(dsdc_pkg::REQ_S2D, sn, 0, 0, 0);
			end else if (pick < 48) begin
				push_req(dsdc_pkg::REQ_S2D, $urandom_range(131071, 0), 0, 0, 0);
			end else if (pick < 85) begin
				y = $urandom_range(END_YR - 1, FIRST_YR);
				m = $urandom_range(12, 1);
				push_req(dsdc_pkg::REQ_D2S, 0, y, m, $urandom_range(month_days(y, m), 1));
			end else if (pick < 92) begin
				// Valid year and month, day anywhere in its field
				y = $urandom_range(END_YR - 1, FIRST_YR);
				push_req(dsdc_pkg::REQ_D2S, 0, y, $urandom_range(12, 1),
					$urandom_range(31, 0));
			end else begin
				push_req(dsdc_pkg::REQ_D2S, 0, $urandom_range(4095, 0),
					$urandom_range(15, 0), $urandom_range(31, 0));
			end
		end
	endtask

	// Hold until the driver has handed over every queued request
	task automatic wait_drained();
		while (req_q.size() != 0 || start)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Driver: change inputs on the falling edge only
	// ---------------------------------------------------------------

	always @(negedge clk) begin
		// Offer a new request once the previous one was taken or none is up
		if (arst_n && (!start || taken)) begin
			if (req_q.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
				request <= req_q.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: sample on the rising edge, check, predict, watch for hangs
	// ---------------------------------------------------------------

	task automatic report_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatch_cnt++;
		end
	endtask

	always @(posedge clk) begin
		dsdc_pkg::res_t want;
		logic accept;
		accept = arst_n && start && !busy;
		taken <= accept;
		if (arst_n) begin
			// Check the result first: a new request may be taken in the done cycle
			if (done) begin
				if (answer_q.size() == 0) begin
					$display("%0t: unexpected result: actual %h", $time, result);
					mismatch_cnt++;
				end else begin
					want = answer_q.pop_front();
					report_field("serial_out", want.serial_out, result.serial_out);
					report_field("year_out",   want.year_out,   result.year_out);
					report_field("month_out",  want.month_out,  result.month_out);
					report_field("day_out",    want.day_out,    result.day_out);
					report_field("bad_input",  want.bad_input,  result.bad_input);
				end
			end
			if (accept)
				answer_q.push_back(convert_date(request));
			// Count cycles where nothing moves in either direction
			if (accept || done)
				stall_cnt = 0;
			else
				stall_cnt++;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequence: reset, directed cases, three random phases, drain
	// ---------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		taken = 1'b0;
		idle_pct = 31;
		mismatch_cnt = 0;
		stall_cnt = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Serial to date: field extremes, last day, just past it, leap day handling
		push_req(dsdc_pkg::REQ_S2D, 0, 0, 0, 0);
		push_req(dsdc_pkg::REQ_S2D, LAST_SERIAL, 0, 0, 0);
		push_req(dsdc_pkg::REQ_S2D, LAST_SERIAL + 1, 0, 0, 0);
		push_req(dsdc_pkg::REQ_S2D, 131071, 0, 0, 0);
		push_req(dsdc_pkg::REQ_S2D, 59, 0, 0, 0);                    // 1 Mar of a non-leap century
		push_req(dsdc_pkg::REQ_S2D, jan1_serial(2000) - 1, 0, 0, 0); // 31 Dec 1999
		push_req(dsdc_pkg::REQ_S2D, jan1_serial(2000) + 58, 0, 0, 0);
		push_req(dsdc_pkg::REQ_S2D, jan1_serial(2000) + 59, 0, 0, 0); // 29 Feb 2000
		push_req(dsdc_pkg::REQ_S2D, jan1_serial(2000) + 60, 0, 0, 0);
		push_req(dsdc_pkg::REQ_S2D, jan1_serial(2004) + 365, 0, 0, 0); // 31 Dec of a leap year
		// Date to serial: range ends, leap rules, bad month and day values
		push_req(dsdc_pkg::REQ_D2S, 0, FIRST_YR, 1, 1);
		push_req(dsdc_pkg::REQ_D2S, 0, END_YR - 1, 12, 31);
		push_req(dsdc_pkg::REQ_D2S, 0, FIRST_YR - 1, 12, 31);
		push_req(dsdc_pkg::REQ_D2S, 0, END_YR, 1, 1);
		push_req(dsdc_pkg::REQ_D2S, 0, 0, 0, 0);
		push_req(dsdc_pkg::REQ_D2S, 0, 4095, 15, 31);
		push_req(dsdc_pkg::REQ_D2S, 0, 2000, 2, 29);
		push_req(dsdc_pkg::REQ_D2S, 0, 1900, 2, 29);
		push_req(dsdc_pkg::REQ_D2S, 0, 2001, 2, 29);
		push_req(dsdc_pkg::REQ_D2S, 0, 2000, 0, 10);
		push_req(dsdc_pkg::REQ_D2S, 0, 2000, 13, 10);
		push_req(dsdc_pkg::REQ_D2S, 0, 2000, 4, 31);
		push_req(dsdc_pkg::REQ_D2S, 0, 2000, 4, 0);
		push_req(dsdc_pkg::REQ_D2S, 0, 2024, 3, 1);

		push_random(650);
		wait_drained();
		idle_pct = 66;
		push_random(650);
		wait_drained();
		idle_pct = 0;
		push_random(700);
		wait_drained();

		// Let every outstanding answer come back, then linger a little
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_cnt == 0 && answer_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
